### rtl/core/cba_pkg.sv
package cba_pkg;

	localparam int NUM_BLOCKS  = 1024;
	localparam int BLOCK_BYTES = 64;

	localparam int BLK_W = 10;
	localparam int CNT_W = 11;
	localparam int OFS_W = 16;

	localparam int ROW_W  = 32;
	localparam int ROWS   = NUM_BLOCKS / ROW_W;
	localparam int ROW_AW = $clog2(ROWS);
	localparam int BIT_AW = $clog2(ROW_W);

	localparam int RESERVED_RAW = NUM_BLOCKS / BLOCK_BYTES;
	localparam int RESERVED     = (RESERVED_RAW > NUM_BLOCKS) ? NUM_BLOCKS : RESERVED_RAW;
	localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef struct packed {
		logic load;
		logic rd_issue;
		logic take_hit;
		logic advance;
		logic wr;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic in_skip;
		logic in_release;
		logic rd_vld;
		logic hit;
		logic row_last;
		logic rd_at_end;
		logic wr_last;
	} sts_t;

	function automatic logic [ROW_W-1:0] reset_row(input logic [ROW_AW-1:0] row);
		logic [ROW_W-1:0] bits;
		bits = '0;
		for (int b = 0; b < ROW_W; b++) begin
			bits[b] = ((int'(row) * ROW_W + b) < RESERVED);
		end
		return bits;
	endfunction

endpackage

### rtl/core/cba_req_if.sv
interface cba_req_if;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [cba_pkg::BLK_W-1:0] start_block;
	logic [cba_pkg::CNT_W-1:0] span;

	modport source (output valid, output mode, output start_block, output span,
		input ready);
	modport sink (input valid, input mode, input start_block, input span,
		output ready);
endinterface

### rtl/core/cba_rsp_if.sv
interface cba_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [cba_pkg::BLK_W-1:0] first_block;
	logic [cba_pkg::OFS_W-1:0] byte_offset;

	modport source (output valid, output found, output first_block, output byte_offset,
		input ready);
	modport sink (input valid, input found, input first_block, input byte_offset,
		output ready);
endinterface

### rtl/core/cba_datapath.sv
module cba_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      mode,
	input  logic [cba_pkg::BLK_W-1:0] start_block,
	input  logic [cba_pkg::CNT_W-1:0] span,
	input  cba_pkg::ctl_t             cmd,
	output cba_pkg::sts_t             sts,
	output logic                      found,
	output logic [cba_pkg::BLK_W-1:0] first_block,
	output logic [cba_pkg::OFS_W-1:0] byte_offset
);

	logic [cba_pkg::ROW_W-1:0]  mem_q [cba_pkg::ROWS];
	logic [cba_pkg::ROWS-1:0]   vld_q;
	logic [cba_pkg::ROW_W-1:0]  mem_rd_s1;
	logic                       row_vld_s1;
	logic [cba_pkg::ROW_AW-1:0] row_s1;
	logic                       rd_vld_s1;

	logic                       mode_q;
	logic [cba_pkg::CNT_W-1:0]  count_q;
	logic [cba_pkg::CNT_W-1:0]  run_q;
	logic [cba_pkg::BLK_W-1:0]  start_q;
	logic [cba_pkg::BLK_W-1:0]  end_q;
	logic [cba_pkg::ROW_AW-1:0] rd_row_q;
	logic                       found_q;
	logic [cba_pkg::BLK_W-1:0]  res_blk_q;

	logic                       out_found_q;
	logic [cba_pkg::BLK_W-1:0]  out_blk_q;
	logic [cba_pkg::OFS_W-1:0]  out_ofs_q;

	logic [cba_pkg::ROW_W-1:0]  row_bits;
	logic [cba_pkg::ROW_W-1:0]  hit_vec;
	logic [cba_pkg::CNT_W-1:0]  run_out;
	logic [cba_pkg::BIT_AW-1:0] hit_pos;
	logic                       hit_any;
	logic [cba_pkg::BLK_W-1:0]  hit_idx;
	logic [cba_pkg::CNT_W-1:0]  hit_start_w;
	logic [cba_pkg::BLK_W-1:0]  hit_start;
	logic [cba_pkg::BIT_AW-1:0] lo_bit;
	logic [cba_pkg::BIT_AW-1:0] hi_bit;
	logic [cba_pkg::ROW_W-1:0]  mark_mask;
	logic [cba_pkg::ROW_W-1:0]  new_row;
	logic [cba_pkg::BLK_W+1:0]  rel_sum;
	logic [cba_pkg::BLK_W-1:0]  rel_end;
	logic                       cnt_zero;
	logic                       cnt_over;

	assign row_bits = row_vld_s1 ? mem_rd_s1 : cba_pkg::reset_row(row_s1);

	always_comb begin
		logic                       h_fnd;
		logic [cba_pkg::BIT_AW-1:0] h_idx;
		logic [cba_pkg::CNT_W-1:0]  len;
		hit_vec = '0;
		run_out = '0;
		for (int p = 0; p < cba_pkg::ROW_W; p++) begin
			h_fnd = 1'b0;
			h_idx = '0;
			for (int q = 0; q < cba_pkg::ROW_W; q++) begin
				if (q <= p && row_bits[q]) begin
					h_fnd = 1'b1;
					h_idx = cba_pkg::BIT_AW'(q);
				end
			end
			if (!h_fnd) begin
				len = run_q + cba_pkg::CNT_W'(p + 1);
			end else begin
				len = cba_pkg::CNT_W'(p) - cba_pkg::CNT_W'(h_idx);
			end
			hit_vec[p] = (len >= count_q);
			if (p == cba_pkg::ROW_W - 1) begin
				run_out = len;
			end
		end
	end

	always_comb begin
		hit_pos = '0;
		for (int q = cba_pkg::ROW_W - 1; q >= 0; q--) begin
			if (hit_vec[q]) begin
				hit_pos = cba_pkg::BIT_AW'(q);
			end
		end
	end

	assign hit_any     = |hit_vec;
	assign hit_idx     = {row_s1, hit_pos};
	assign hit_start_w = cba_pkg::CNT_W'(hit_idx) - count_q + cba_pkg::CNT_W'(1);
	assign hit_start   = hit_start_w[cba_pkg::BLK_W-1:0];

	assign lo_bit    = (row_s1 == start_q[cba_pkg::BLK_W-1 -: cba_pkg::ROW_AW]) ?
		start_q[cba_pkg::BIT_AW-1:0] : '0;
	assign hi_bit    = (row_s1 == end_q[cba_pkg::BLK_W-1 -: cba_pkg::ROW_AW]) ?
		end_q[cba_pkg::BIT_AW-1:0] : '1;
	assign mark_mask = ({cba_pkg::ROW_W{1'b1}} << lo_bit) &
		({cba_pkg::ROW_W{1'b1}} >> (cba_pkg::BIT_AW'(cba_pkg::ROW_W - 1) - hi_bit));
	assign new_row   = (mode_q == cba_pkg::MODE_RELEASE) ? (row_bits & ~mark_mask) :
		(row_bits | mark_mask);

	assign rel_sum  = {2'b00, start_block} + {1'b0, span} - (cba_pkg::BLK_W + 2)'(1);
	assign rel_end  = (rel_sum[cba_pkg::BLK_W+1:cba_pkg::BLK_W] != 2'b00) ?
		'1 : rel_sum[cba_pkg::BLK_W-1:0];
	assign cnt_zero = (span == '0);
	assign cnt_over = (span > cba_pkg::CNT_W'(cba_pkg::NUM_BLOCKS));

	assign sts.in_release = (mode == cba_pkg::MODE_RELEASE);
	assign sts.in_skip    = cnt_zero || ((mode == cba_pkg::MODE_ALLOC) && cnt_over);
	assign sts.rd_vld     = rd_vld_s1;
	assign sts.hit        = hit_any;
	assign sts.row_last   = (row_s1 == '1);
	assign sts.rd_at_end  = (rd_row_q == end_q[cba_pkg::BLK_W-1 -: cba_pkg::ROW_AW]);
	assign sts.wr_last    = rd_vld_s1 && (row_s1 == end_q[cba_pkg::BLK_W-1 -: cba_pkg::ROW_AW]);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[row_s1] <= new_row;
		end
		if (cmd.rd_issue) begin
			mem_rd_s1 <= mem_q[rd_row_q];
			row_vld_s1 <= vld_q[rd_row_q];
			row_s1 <= rd_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_issue;
			if (cmd.wr) begin
				vld_q[row_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			count_q <= span;
			run_q <= '0;
			start_q <= start_block;
			end_q <= rel_end;
			found_q <= (mode == cba_pkg::MODE_RELEASE);
			res_blk_q <= '0;
			rd_row_q <= (mode == cba_pkg::MODE_RELEASE) ?
				start_block[cba_pkg::BLK_W-1 -: cba_pkg::ROW_AW] : '0;
		end else if (cmd.take_hit) begin
			start_q <= hit_start;
			end_q <= hit_idx;
			found_q <= 1'b1;
			res_blk_q <= hit_start;
			rd_row_q <= hit_start[cba_pkg::BLK_W-1 -: cba_pkg::ROW_AW];
		end else begin
			if (cmd.rd_issue) begin
				rd_row_q <= rd_row_q + cba_pkg::ROW_AW'(1);
			end
			if (cmd.advance) begin
				run_q <= run_out;
			end
		end
		if (cmd.out_load) begin
			out_found_q <= found_q;
			out_blk_q <= res_blk_q;
			out_ofs_q <= cba_pkg::OFS_W'(res_blk_q) << cba_pkg::BLOCK_SHIFT;
		end
	end

	assign found       = out_found_q;
	assign first_block = out_blk_q;
	assign byte_offset = out_ofs_q;

endmodule

### rtl/core/cba_ctrl.sv
module cba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  cba_pkg::sts_t sts,
	output cba_pkg::ctl_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_MARK = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   issued_all_q;
	logic   out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.in_skip) begin
						state_d = S_RESP;
					end else if (sts.in_release) begin
						state_d = S_MARK;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (sts.rd_vld && sts.hit) begin
					cmd.take_hit = 1'b1;
					state_d = S_MARK;
				end else begin
					cmd.rd_issue = 1'b1;
					if (sts.rd_vld) begin
						cmd.advance = 1'b1;
						if (sts.row_last) begin
							state_d = S_RESP;
						end
					end
				end
			end
			S_MARK: begin
				cmd.rd_issue = !issued_all_q;
				if (sts.rd_vld) begin
					cmd.wr = 1'b1;
					if (sts.wr_last) begin
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_all_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != S_MARK) begin
				issued_all_q <= 1'b0;
			end else if (cmd.rd_issue && sts.rd_at_end) begin
				issued_all_q <= 1'b1;
			end
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

### rtl/core/contiguous_block_allocator.sv
// First-fit contiguous allocator over a 1024-entry block occupancy map.
// req carries one word per request: mode (allocate or release), start_block
// and span. rsp returns one word per request: found, first_block and
// byte_offset (first_block times the block size).
// The map is held as 32 rows of 32 blocks in a memory with registered read.
// An allocate scans rows from row 0, one row per cycle, then rewrites the
// rows covered by the run, one per cycle. A failed allocate scans all 32
// rows before it answers. A release rewrites only its rows. A request with
// a count of 0, or an allocate above the map size, answers without
// touching the map. One request is worked on at a time; req.ready is high
// only idle, from the cycle after the response word is loaded.
// Reset returns the map to its initial contents at once: blocks 0 to 15 are
// used and all others free. No clearing pass is needed.
// rsp has an output register: while rsp.ready is low the word holds, and the
// block still accepts and works on the next request, waiting only to deliver.
module contiguous_block_allocator (
	input  logic       clk,
	input  logic       arst_n,
	cba_req_if.sink    req,
	cba_rsp_if.source  rsp
);

	cba_pkg::ctl_t cmd;
	cba_pkg::sts_t sts;

	cba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cba_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (req.mode),
		.start_block (req.start_block),
		.span        (req.span),
		.cmd         (cmd),
		.sts         (sts),
		.found       (rsp.found),
		.first_block (rsp.first_block),
		.byte_offset (rsp.byte_offset)
	);

endmodule

### rtl/core/cba_checker.sv
module cba_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      found,
	input logic [cba_pkg::BLK_W-1:0] first_block,
	input logic [cba_pkg::OFS_W-1:0] byte_offset
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("response valid during reset");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> first_block == '0 && byte_offset == '0)
		else $error("failed allocation carries nonzero block");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> byte_offset == (cba_pkg::OFS_W'(first_block) << cba_pkg::BLOCK_SHIFT))
		else $error("byte offset does not match first block");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(first_block) && $stable(found))
		else $error("stalled response word changed");

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.found       (rsp.found),
	.first_block (rsp.first_block),
	.byte_offset (rsp.byte_offset)
);
